[rtl/core/dqr_pkg.sv]
// Shared widths and the cell-row command for the bounded deque with remove.
// No dependencies; imported by dqr_cell, bounded_deque_with_remove_unit and the testbench.
package dqr_pkg;

  localparam int DEPTH     = 64;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int MODE_W    = 3;
  localparam int POS_W     = 7;
  localparam int CNT_OUT_W = 7;
  localparam int ST_W      = 2;
  localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int S_TDATA_W = ((MODE_W + DATA_W + POS_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DATA_W + CNT_OUT_W + ST_W + 7) / 8) * 8;

  // Broadcast to every cell of the row in each cycle.
  typedef struct packed {
    logic              shl;      // each cell takes its right neighbour
    logic              shr;      // each cell takes its left neighbour
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
  } dqr_cmd_t;

endpackage

[rtl/core/bounded_deque_with_remove_unit.sv]
// Bounded deque of signed 32-bit values, DEPTH entries, held in order from the front in a
// row of cells that shift left or right together. Each request returns one result. Push,
// pop, clear, get and the unused mode register the request, then act on the cell row and
// load the result register once the output side is free. Remove rotates the row one entry
// per cycle, dropping matches and re-appending the survivors behind the unprocessed ones.
// One request is in flight at a time; a new one is accepted while the previous result
// still waits on the output side. Reset needs no clearing pass.
// Depends on dqr_pkg and dqr_cell.
module bounded_deque_with_remove_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // mode[2:0], value[34:3], position[41:35], zero pad
  input  logic [dqr_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // read_value[31:0], entry_count[38:32], status[40:39], zero pad
  output logic [dqr_pkg::M_TDATA_W-1:0] m_tdata
);
  import dqr_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_GET        = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REMOVE
  } state_t;

  state_t                state;
  logic [MODE_W-1:0]     req_mode;
  logic [DATA_W-1:0]     req_value;
  logic [POS_W-1:0]      req_pos;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      rem_left;
  logic [CNT_W-1:0]      rem_kept;
  logic [DATA_W-1:0]     out_value;
  logic [CNT_OUT_W-1:0]  out_count;
  status_t               out_status;

  dqr_cmd_t              cmd;
  logic [DATA_W-1:0]     cell_data [DEPTH];
  logic [DATA_W-1:0]     cell_tap  [DEPTH];
  logic [DATA_W-1:0]     rd_value;
  logic                  out_free;
  logic                  full;
  logic                  empty;
  logic                  in_range;
  logic                  keep;
  logic                  load;
  logic [CNT_W-1:0]      res_count;
  logic [DATA_W-1:0]     res_value;
  status_t               res_status;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = cell_data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = cell_data[gi+1];
      end
      dqr_cell u_cell (
        .clk        (clk),
        .idx        (IDX_W'(gi)),
        .cmd        (cmd),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (cell_data[gi]),
        .tap        (cell_tap[gi])
      );
    end
  endgenerate

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = M_TDATA_W'({out_status, out_count, out_value});

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_value = rd_value | cell_tap[i];
    end
  end

  always_comb begin
    out_free   = !m_tvalid || m_tready;
    full       = (count == CNT_W'(DEPTH));
    empty      = (count == '0);
    in_range   = (CMP_W'(req_pos) < CMP_W'(count));
    keep       = (cell_data[0] != req_value);
    cmd        = '0;
    cmd.wr_data = req_value;
    cmd.rd_addr = IDX_W'(req_pos);
    load       = 1'b0;
    res_count  = count;
    res_value  = '0;
    res_status = ST_OK;
    unique case (state)
      S_EXEC: begin
        if (req_mode != OP_REMOVE) begin
          load = out_free;
        end
        case (req_mode)
          OP_PUSH_BACK: begin
            if (full) begin
              res_status = ST_FULL;
            end else begin
              cmd.wr_en   = load;
              cmd.wr_addr = count[IDX_W-1:0];
              res_count   = count + 1'b1;
            end
          end
          OP_PUSH_FRONT: begin
            if (full) begin
              res_status = ST_FULL;
            end else begin
              cmd.shr     = load;
              cmd.wr_en   = load;
              cmd.wr_addr = '0;
              res_count   = count + 1'b1;
            end
          end
          OP_POP_BACK: begin
            if (empty) begin
              res_status = ST_EMPTY;
            end else begin
              res_count = count - 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (empty) begin
              res_status = ST_EMPTY;
            end else begin
              cmd.shl   = load;
              res_count = count - 1'b1;
            end
          end
          OP_CLEAR: begin
            res_count = '0;
          end
          OP_GET: begin
            if (in_range) begin
              res_value = rd_value;
            end else begin
              res_status = ST_RANGE;
            end
          end
          default: begin
          end
        endcase
      end
      S_REMOVE: begin
        if (rem_left != '0) begin
          // Rotate the head out; re-append it behind the survivors if it stays.
          cmd.shl     = 1'b1;
          cmd.wr_en   = keep;
          cmd.wr_data = cell_data[0];
          cmd.wr_addr = IDX_W'(rem_left + rem_kept - 1'b1);
        end else begin
          load      = out_free;
          res_count = rem_kept;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      rem_left <= '0;
      rem_kept <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_mode  <= s_tdata[MODE_W-1:0];
            req_value <= s_tdata[MODE_W +: DATA_W];
            req_pos   <= s_tdata[MODE_W + DATA_W +: POS_W];
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (req_mode == OP_REMOVE) begin
            rem_left <= count;
            rem_kept <= '0;
            state    <= S_REMOVE;
          end
        end
        S_REMOVE: begin
          if (rem_left != '0) begin
            rem_left <= rem_left - 1'b1;
            if (keep) begin
              rem_kept <= rem_kept + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load) begin
        m_tvalid   <= 1'b1;
        out_value  <= res_value;
        out_count  <= CNT_OUT_W'(res_count);
        out_status <= res_status;
        count      <= res_count;
        state      <= S_IDLE;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_remove_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_REMOVE) |-> ((CNT_W + 1)'(rem_left) + (CNT_W + 1)'(rem_kept)
                             <= (CNT_W + 1)'(count)))
    else $error("remove walk exceeds stored span");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_EXEC || $past(state) == S_REMOVE))
    else $error("result raised outside an active request");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_FULL) |-> (out_count == CNT_OUT_W'(DEPTH)))
    else $error("push dropped while not full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_EMPTY) |-> (out_count == '0))
    else $error("pop flagged empty with entries stored");
`endif

endmodule

[rtl/core/dqr_cell.sv]
// One cell of the deque row: holds the entry at one position from the front.
// Depends on dqr_pkg for widths and the broadcast command.
module dqr_cell (
  input  logic                      clk,
  input  logic [dqr_pkg::IDX_W-1:0]  idx,
  input  dqr_pkg::dqr_cmd_t          cmd,
  input  logic [dqr_pkg::DATA_W-1:0] left_data,
  input  logic [dqr_pkg::DATA_W-1:0] right_data,
  output logic [dqr_pkg::DATA_W-1:0] data,
  output logic [dqr_pkg::DATA_W-1:0] tap
);
  import dqr_pkg::*;

  // A direct write wins over the shift, so a push front lands in cell zero.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && (cmd.wr_addr == idx)) begin
      data <= cmd.wr_data;
    end else if (cmd.shr) begin
      data <= left_data;
    end else if (cmd.shl) begin
      data <= right_data;
    end
  end

  assign tap = (cmd.rd_addr == idx) ? data : '0;

endmodule

[verif/bounded_deque_with_remove_unit_test.sv]
// Self-checking testbench for bounded_deque_with_remove_unit: directed rows, then random
// fill, drain and mixed runs, checked against an in-bench queue predictor.
// Depends on dqr_pkg and the unit under test.
module bounded_deque_with_remove_unit_test;
  import dqr_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_BACK, OP_PUSH_FRONT, OP_POP_BACK, OP_POP_FRONT,
    OP_REMOVE, OP_CLEAR, OP_GET, OP_SPARE
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK, ST_EMPTY_POP, ST_BAD_POS, ST_FULL_DROP
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0]    read_value;
    logic [CNT_OUT_W-1:0] count;
    status_e              status;
  } reply_t;

  typedef struct packed {
    request_t req;
    logic     fixed;
    reply_t   want;
  } plan_row_t;

  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_LEN   = 2 * DEPTH + 10;
  localparam int COUNT_LSB    = DATA_W;
  localparam int STATUS_LSB   = DATA_W + CNT_OUT_W;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;

  bounded_deque_with_remove_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  logic [DATA_W-1:0] mirror_entries[$];   // deque contents, front first
  reply_t            awaited_replies[$];
  plan_row_t         plan[$];

  bit steady = 1'b0;
  int sent_items, results_seen, mismatches;
  int full_drops, empty_pops, range_misses, removed_total, peak_count;
  int idle_cycles;

  function automatic reply_t deque_apply(request_t r);
    reply_t            y;
    logic [DATA_W-1:0] survivors[$];
    y.read_value = '0;
    y.status     = ST_OK;
    case (r.op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (mirror_entries.size() >= DEPTH) begin
          y.status = ST_FULL_DROP;
          full_drops++;
        end else if (r.op == OP_PUSH_BACK) begin
          mirror_entries.insert(mirror_entries.size(), r.value);
        end else begin
          mirror_entries.insert(0, r.value);
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (mirror_entries.size() == 0) begin
          y.status = ST_EMPTY_POP;
          empty_pops++;
        end else if (r.op == OP_POP_BACK) begin
          mirror_entries.delete(mirror_entries.size() - 1);
        end else begin
          mirror_entries.delete(0);
        end
      end
      OP_REMOVE: begin
        // keep the order of whatever survives
        foreach (mirror_entries[i])
          if (mirror_entries[i] != r.value) survivors.insert(survivors.size(), mirror_entries[i]);
        removed_total += mirror_entries.size() - survivors.size();
        mirror_entries = survivors;
      end
      OP_CLEAR: mirror_entries.delete();
      OP_GET: begin
        if (r.position >= mirror_entries.size()) begin
          y.status = ST_BAD_POS;
          range_misses++;
        end else begin
          y.read_value = mirror_entries[r.position];
        end
      end
      default: ;
    endcase
    y.count = CNT_OUT_W'(mirror_entries.size());
    if (mirror_entries.size() > peak_count) peak_count = mirror_entries.size();
    return y;
  endfunction

  // Draw one request; push_pct and pop_pct steer the mix, the rest is get, remove,
  // clear and the spare mode.
  function automatic request_t make_request(int push_pct, int pop_pct);
    request_t r;
    int       roll;
    int       pick;
    int       held;
    held = mirror_entries.size();
    pick = $urandom_range(9);
    if (pick < 4) begin
      r.value = $urandom();
    end else if (pick < 8 || held == 0) begin
      case ($urandom_range(7))
        0: r.value = 32'h0000_0000;
        1: r.value = 32'h0000_0001;
        2: r.value = 32'hffff_ffff;
        3: r.value = 32'h7fff_ffff;
        4: r.value = 32'h8000_0000;
        5: r.value = 32'h0000_0005;
        6: r.value = 32'hffff_fffe;
        default: r.value = 32'h5a5a_a5a5;
      endcase
    end else begin
      r.value = mirror_entries[$urandom_range(held - 1)];
    end
    if (held > 0 && $urandom_range(3) != 0) r.position = POS_W'($urandom_range(held - 1));
    else r.position = POS_W'($urandom_range(127));
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      r.op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end else if (roll < push_pct + pop_pct) begin
      r.op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
    end else begin
      pick = $urandom_range(99);
      if (pick < 55) r.op = OP_GET;
      else if (pick < 80) r.op = OP_REMOVE;
      else if (pick < 88) r.op = OP_CLEAR;
      else r.op = OP_SPARE;
    end
    return r;
  endfunction

  task automatic add_row(input op_e op, input logic [DATA_W-1:0] value,
                         input logic [POS_W-1:0] position, input logic fixed,
                         input logic [DATA_W-1:0] rd, input int cnt, input status_e st);
    plan_row_t row;
    row.req.op          = op;
    row.req.value       = value;
    row.req.position    = position;
    row.fixed           = fixed;
    row.want.read_value = rd;
    row.want.count      = CNT_OUT_W'(cnt);
    row.want.status     = st;
    plan.insert(plan.size(), row);
  endtask

  // Present one request, hold it until taken, then predict its reply.
  task automatic issue(input request_t r, input logic fixed, input reply_t want);
    reply_t predicted;
    s_tdata  <= S_TDATA_W'({r.position, r.value, r.op});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predicted = deque_apply(r);
    awaited_replies.insert(awaited_replies.size(), fixed ? want : predicted);
    sent_items++;
    if (!steady && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  always @(posedge clk) m_tready <= steady || ($urandom_range(99) >= 12);

  always @(posedge clk) begin : check_results
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h with no request outstanding", m_tdata);
      end else begin
        want = awaited_replies[0];
        awaited_replies.delete(0);
        if (want.read_value !== m_tdata[0 +: DATA_W] ||
            want.count      !== m_tdata[COUNT_LSB +: CNT_OUT_W] ||
            want.status     !== m_tdata[STATUS_LSB +: ST_W]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d: expected value %h count %0d status %0d",
                     results_seen, want.read_value, want.count, want.status);
            $display("  got value %h count %0d status %0d",
                     m_tdata[0 +: DATA_W], m_tdata[COUNT_LSB +: CNT_OUT_W],
                     m_tdata[STATUS_LSB +: ST_W]);
          end
        end
      end
    end
  end

  // Abort when no request and no result moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d results outstanding",
               idle_cycles, awaited_replies.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    request_t r;
    reply_t   none;
    int       random_start, episode, extra, span;
    none = '0;

    // From reset: error codes on the empty deque, extremes, then mixed checks.
    add_row(OP_GET,        32'h0000_0000, 7'd0,   1, 32'h0, 0, ST_BAD_POS);
    add_row(OP_POP_BACK,   32'h0000_0000, 7'd0,   1, 32'h0, 0, ST_EMPTY_POP);
    add_row(OP_POP_FRONT,  32'hffff_ffff, 7'd127, 1, 32'h0, 0, ST_EMPTY_POP);
    add_row(OP_REMOVE,     32'h0000_0000, 7'd0,   1, 32'h0, 0, ST_OK);
    add_row(OP_SPARE,      32'hffff_ffff, 7'd127, 1, 32'h0, 0, ST_OK);
    add_row(OP_PUSH_BACK,  32'h7fff_ffff, 7'd0,   1, 32'h0, 1, ST_OK);
    add_row(OP_PUSH_FRONT, 32'h8000_0000, 7'd0,   1, 32'h0, 2, ST_OK);
    add_row(OP_GET,        32'h0000_0000, 7'd0,   1, 32'h8000_0000, 2, ST_OK);
    add_row(OP_GET,        32'h0000_0000, 7'd1,   1, 32'h7fff_ffff, 2, ST_OK);
    add_row(OP_GET,        32'h0000_0000, 7'd127, 1, 32'h0, 2, ST_BAD_POS);
    add_row(OP_GET,        32'h0000_0000, 7'd2,   1, 32'h0, 2, ST_BAD_POS);
    add_row(OP_PUSH_BACK,  32'hffff_ffff, 7'd0,   0, 32'h0, 0, ST_OK);
    add_row(OP_PUSH_FRONT, 32'h0000_0000, 7'd0,   0, 32'h0, 0, ST_OK);
    add_row(OP_PUSH_BACK,  32'h8000_0000, 7'd0,   0, 32'h0, 0, ST_OK);
    add_row(OP_REMOVE,     32'h8000_0000, 7'd0,   0, 32'h0, 0, ST_OK);
    add_row(OP_GET,        32'h0000_0000, 7'd0,   0, 32'h0, 0, ST_OK);
    add_row(OP_GET,        32'h0000_0000, 7'd2,   0, 32'h0, 0, ST_OK);
    add_row(OP_REMOVE,     32'h7fff_fffe, 7'd0,   0, 32'h0, 0, ST_OK);
    add_row(OP_POP_BACK,   32'h0000_0000, 7'd0,   0, 32'h0, 0, ST_OK);
    add_row(OP_POP_FRONT,  32'h0000_0000, 7'd0,   0, 32'h0, 0, ST_OK);
    add_row(OP_SPARE,      32'h1234_5678, 7'd64,  0, 32'h0, 0, ST_OK);
    add_row(OP_CLEAR,      32'h0000_0000, 7'd0,   1, 32'h0, 0, ST_OK);
    add_row(OP_GET,        32'h0000_0000, 7'd0,   1, 32'h0, 0, ST_BAD_POS);
    add_row(OP_PUSH_FRONT, 32'h5555_5555, 7'd0,   0, 32'h0, 0, ST_OK);
    add_row(OP_POP_FRONT,  32'h0000_0000, 7'd0,   0, 32'h0, 0, ST_OK);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) issue(plan[i].req, plan[i].fixed, plan[i].want);

    // Random runs; the first one fills the deque and runs until pushes overflow or its run limit is hit.
    random_start = sent_items;
    episode      = 0;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      steady = (sent_items - random_start >= 700) && (sent_items - random_start < 1100);
      if (episode < 2) begin
        extra = $urandom_range(3, 1);
        span  = 0;
        while (extra > 0 && span < 400) begin
          r = make_request(85, 0);
          if (mirror_entries.size() >= DEPTH &&
              (r.op == OP_PUSH_BACK || r.op == OP_PUSH_FRONT)) extra--;
          issue(r, 1'b0, none);
          span++;
        end
      end else if (episode < 4) begin
        extra = $urandom_range(3, 1);
        span  = 0;
        while (extra > 0 && span < 400) begin
          r = make_request(0, 85);
          if (mirror_entries.size() == 0 &&
              (r.op == OP_POP_BACK || r.op == OP_POP_FRONT)) extra--;
          issue(r, 1'b0, none);
          span++;
        end
      end else begin
        repeat ($urandom_range(60, 20)) issue(make_request(35, 25), 1'b0, none);
      end
      episode = $urandom_range(9);
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    steady   = 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);

    $display("ran %0d requests and checked %0d results, peak occupancy %0d of %0d",
             sent_items, results_seen, peak_count, DEPTH);
    $display("dropped pushes %0d, empty pops %0d, gets out of range %0d, entries removed %0d",
             full_drops, empty_pops, range_misses, removed_total);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, awaited_replies.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/dqr_pkg.sv
rtl/core/dqr_cell.sv
rtl/core/bounded_deque_with_remove_unit.sv
verif/bounded_deque_with_remove_unit_test.sv
